// ===== rtl/core/edt_pkg.sv =====
// Shared types, codes and helpers for the enum declaration tokenizer.
`timescale 1ns / 1ps
package edt_pkg;

   // Longest word that is gathered before it is closed off.
   localparam int MAX_LEXEME_DEFAULT = 32;

   // Token kinds on the result channel.
   localparam logic [3:0] TK_IDENT   = 4'd0;
   localparam logic [3:0] TK_INTEGER = 4'd1;
   localparam logic [3:0] TK_ENUM    = 4'd2;
   localparam logic [3:0] TK_CLASS   = 4'd3;
   localparam logic [3:0] TK_LBRACE  = 4'd4;
   localparam logic [3:0] TK_RBRACE  = 4'd5;
   localparam logic [3:0] TK_SEMI    = 4'd6;
   localparam logic [3:0] TK_EQUALS  = 4'd7;
   localparam logic [3:0] TK_COMMA   = 4'd8;
   localparam logic [3:0] TK_END     = 4'd9;

   // Character codes that steer the scanner.
   localparam logic [7:0] CH_LF     = 8'h0a;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_PLUS   = 8'h2b;
   localparam logic [7:0] CH_MINUS  = 8'h2d;
   localparam logic [7:0] CH_COMMA  = 8'h2c;
   localparam logic [7:0] CH_SLASH  = 8'h2f;
   localparam logic [7:0] CH_STAR   = 8'h2a;
   localparam logic [7:0] CH_SEMI   = 8'h3b;
   localparam logic [7:0] CH_EQUALS = 8'h3d;
   localparam logic [7:0] CH_LBRACE = 8'h7b;
   localparam logic [7:0] CH_RBRACE = 8'h7d;
   localparam logic [7:0] CH_UNDER  = 8'h5f;

   // Keyword spellings.
   localparam logic [7:0] KW_ENUM  [4] = '{8'h65, 8'h6e, 8'h75, 8'h6d};
   localparam logic [7:0] KW_CLASS [5] = '{8'h63, 8'h6c, 8'h61, 8'h73, 8'h73};

   typedef struct packed {
      logic [7:0] character;
      logic       end_of_input;
      logic       leave_enum_mode;
   } req_type;

   typedef struct packed {
      logic [3:0]         token_kind;
      logic signed [31:0] token_value;
      logic [7:0]         name_char;
      logic               token_last;
      logic               item_last;
      logic [15:0]        line_count;
   } rsp_type;

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= 8'h30) && (c <= 8'h39);
   endfunction

   function automatic logic is_letter(input logic [7:0] c);
      return ((c >= 8'h41) && (c <= 8'h5a)) || ((c >= 8'h61) && (c <= 8'h7a)) ||
             (c == CH_UNDER);
   endfunction

   function automatic logic is_sign(input logic [7:0] c);
      return (c == CH_PLUS) || (c == CH_MINUS);
   endfunction

   function automatic rsp_type make_rsp(input logic [3:0] kind, input logic [31:0] value,
                                        input logic [7:0] nch, input logic tlast,
                                        input logic ilast, input logic [15:0] line);
      rsp_type r;
      r.token_kind  = kind;
      r.token_value = value;
      r.name_char   = nch;
      r.token_last  = tlast;
      r.item_last   = ilast;
      r.line_count  = line;
      return r;
   endfunction

endpackage

// ===== rtl/core/enum_declaration_tokenizer.sv =====
// Top level of the enum declaration tokenizer: scanner, word state and result sequencer.
//
//   channel | direction | handshake            | payload
//   req_    | in        | req_valid/req_stall  | req_data (req_type)
//   rsp_    | out       | rsp_valid/rsp_stall  | rsp_data (rsp_type)
//
// An item that flushes an identifier replays it: each stored character is read from
// the word memory (ST_RD) and then presented (ST_CH); a second token after a word is
// presented from ST_PEND, and no new request is taken until the item is done.
// Reset is synchronous and clears all control state; the word memory needs no clear.
// A stalled result holds in the output register and intake waits for it to move.
`timescale 1ns / 1ps
module enum_declaration_tokenizer
   import edt_pkg::*;
#(
   parameter int MAX_LEXEME = MAX_LEXEME_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int IW = $clog2(MAX_LEXEME);
   localparam int LW = $clog2(MAX_LEXEME + 1);
   localparam logic [LW-1:0] MAX_LEN = LW'(MAX_LEXEME);

   // Scanner phases.
   localparam logic [2:0] PH_IDLE  = 3'd0;
   localparam logic [2:0] PH_WORD  = 3'd1;
   localparam logic [2:0] PH_SLASH = 3'd2;
   localparam logic [2:0] PH_BLOCK = 3'd3;
   localparam logic [2:0] PH_LINE  = 3'd4;

   // Sequencer states.
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RD   = 2'd1;
   localparam logic [1:0] ST_CH   = 2'd2;
   localparam logic [1:0] ST_PEND = 2'd3;

   // Control and word registers.
   logic [1:0]    state_ff, state_in;
   logic [2:0]    phase_ff, phase_in;
   logic          saw_ff, saw_in;
   logic          mode_ff, mode_in;
   logic          ae_ff, ae_in;
   logic          ac_ff, ac_in;
   logic [15:0]   depth_ff, depth_in;
   logic [15:0]   line_ff, line_in;
   logic [LW-1:0] len_ff, len_in;
   logic [31:0]   acc_ff, acc_in;
   logic          fdig_ff, fdig_in;
   logic          fid_ff, fid_in;
   logic          fseen_ff, fseen_in;
   logic          neg_ff, neg_in;
   logic [1:0]    km_ff, km_in;
   logic          bank_ff, bank_in;
   logic          rbank_ff, rbank_in;
   logic [IW-1:0] idx_ff, idx_in;
   logic [LW-1:0] rlen_ff, rlen_in;
   logic          pend_ff, pend_in;
   logic [3:0]    pkind_ff, pkind_in;
   logic [31:0]   pval_ff, pval_in;
   rsp_type       rsp_ff, rsp_in;
   logic          rspv_ff;
   logic          load;

   logic          accept;
   logic          slot_free;
   logic [7:0]    ch;
   logic          dig, let_c, sgn, spc, mode_now, mode_after;
   logic          do_add, start_word, do_flush, do_idle, clear_word;
   logic          p_valid, s_valid;
   logic [3:0]    s_kind;
   logic [31:0]   s_value;
   logic [LW-1:0] a_pos, b_len, a_len, f_len;
   logic [31:0]   b_acc, a_acc, f_acc, b_acc10;
   logic          b_dig, b_id, b_seen, b_neg, a_dig, a_id, a_seen, a_neg;
   logic          f_dig, f_id, f_seen, f_neg;
   logic [1:0]    b_km, a_km, f_km;
   logic          fl_enum, fl_class, fl_int, fl_ident;
   logic          wr_bank;
   logic [7:0]    rd_data;
   logic          ch_last;

   assign slot_free = !rspv_ff || !rsp_stall;
   assign req_stall = !((state_ff == ST_IDLE) && slot_free);
   assign accept    = req_valid && !req_stall;

   // Scanner: classify the byte, advance the phase and build or flush the word.
   always_comb begin
      ch         = req_data.character;
      dig        = is_digit(ch);
      let_c      = is_letter(ch);
      sgn        = is_sign(ch);
      spc        = (ch == CH_SPACE) || (ch == CH_TAB) || (ch == CH_LF);
      mode_now   = mode_ff && !req_data.leave_enum_mode;
      phase_in   = phase_ff;
      saw_in     = saw_ff;
      do_add     = 1'b0;
      start_word = 1'b0;
      do_flush   = 1'b0;
      do_idle    = 1'b0;
      clear_word = 1'b0;
      p_valid    = 1'b0;
      s_kind     = TK_END;
      s_value    = '0;
      depth_in   = depth_ff;
      line_in    = line_ff;

      if (req_data.end_of_input) begin
         do_flush   = (phase_ff == PH_WORD);
         phase_in   = PH_IDLE;
         clear_word = 1'b1;
         saw_in     = 1'b0;
      end else begin
         if (ch == CH_LF) begin
            line_in = line_ff + 16'd1;
         end
         case (phase_ff)
            PH_BLOCK: begin
               if (saw_ff && (ch == CH_SLASH)) begin
                  phase_in = PH_IDLE;
               end else begin
                  saw_in = (ch == CH_STAR);
               end
            end
            PH_LINE: begin
               if (ch == CH_LF) begin
                  phase_in = PH_IDLE;
               end
            end
            PH_SLASH: begin
               if (ch == CH_STAR) begin
                  phase_in = PH_BLOCK;
                  saw_in   = 1'b0;
               end else if (ch == CH_SLASH) begin
                  phase_in = PH_LINE;
               end else begin
                  phase_in = PH_IDLE;
                  do_idle  = !spc;
               end
            end
            PH_WORD: begin
               phase_in = PH_IDLE;
               if (dig || let_c) begin
                  do_add = 1'b1;
                  if ((len_ff + LW'(1)) >= MAX_LEN) begin
                     do_flush = 1'b1;
                  end else begin
                     phase_in = PH_WORD;
                  end
               end else begin
                  do_flush = 1'b1;
                  do_idle  = !spc;
               end
            end
            default: begin
               phase_in = PH_IDLE;
               do_idle  = !spc;
            end
         endcase
      end

      // A byte handled between words.
      if (do_idle) begin
         case (ch)
            CH_LBRACE: begin
               if (depth_ff != 16'hffff) begin
                  depth_in = depth_ff + 16'd1;
               end
               p_valid = 1'b1;
               s_kind  = TK_LBRACE;
               s_value = {16'd0, depth_in};
            end
            CH_RBRACE: begin
               if (depth_ff != 16'd0) begin
                  depth_in = depth_ff - 16'd1;
               end
               p_valid = 1'b1;
               s_kind  = TK_RBRACE;
               s_value = {16'd0, depth_ff};
            end
            CH_EQUALS: begin
               p_valid = 1'b1;
               s_kind  = TK_EQUALS;
            end
            CH_SEMI: begin
               p_valid = 1'b1;
               s_kind  = TK_SEMI;
            end
            CH_COMMA: begin
               p_valid = 1'b1;
               s_kind  = TK_COMMA;
            end
            CH_SLASH: begin
               phase_in = PH_SLASH;
            end
            default: begin
               if (dig || let_c || sgn) begin
                  start_word = 1'b1;
                  do_add     = 1'b1;
                  phase_in   = PH_WORD;
               end
            end
         endcase
      end

      // Add the byte to the word, starting from an empty word when one begins.
      b_len   = start_word ? '0 : len_ff;
      b_acc   = start_word ? '0 : acc_ff;
      b_dig   = start_word ? 1'b0 : fdig_ff;
      b_id    = start_word ? 1'b0 : fid_ff;
      b_seen  = start_word ? 1'b0 : fseen_ff;
      b_neg   = start_word ? 1'b0 : neg_ff;
      b_km    = start_word ? 2'b00 : km_ff;
      a_pos   = b_len;
      a_dig   = b_dig;
      a_id    = b_id;
      a_seen  = b_seen;
      a_neg   = b_neg;
      a_km    = b_km;
      a_acc   = b_acc;
      b_acc10 = (b_acc << 3) + (b_acc << 1);
      if (a_pos == '0) begin
         a_dig = !let_c;
         a_id  = let_c;
         a_seen = 1'b0;
         a_neg = (ch == CH_MINUS);
         a_km  = 2'b11;
      end
      if (dig) begin
         a_seen = 1'b1;
         a_acc  = b_acc10 + {28'd0, ch[3:0]};
      end else if (let_c) begin
         a_dig = 1'b0;
      end
      if ((a_pos >= LW'(4)) || (KW_ENUM[a_pos[1:0]] != ch)) begin
         a_km[0] = 1'b0;
      end
      if ((a_pos >= LW'(5)) || (KW_CLASS[(a_pos < LW'(5)) ? a_pos[2:0] : 3'd0] != ch)) begin
         a_km[1] = 1'b0;
      end
      a_len = a_pos + LW'(1);

      // The word that a flush looks at.
      if (do_add && !start_word) begin
         f_len = a_len; f_acc = a_acc; f_dig = a_dig; f_id = a_id;
         f_seen = a_seen; f_neg = a_neg; f_km = a_km;
      end else begin
         f_len = len_ff; f_acc = acc_ff; f_dig = fdig_ff; f_id = fid_ff;
         f_seen = fseen_ff; f_neg = neg_ff; f_km = km_ff;
      end

      fl_enum  = do_flush && (f_len == LW'(4)) && f_km[0];
      fl_class = do_flush && !fl_enum && (f_len == LW'(5)) && f_km[1];
      fl_int   = do_flush && !fl_enum && !fl_class && f_dig && f_seen && mode_now;
      fl_ident = do_flush && !fl_enum && !fl_class && !(f_dig && f_seen) && f_id &&
                 (f_len != '0) && (mode_now || ae_ff || ac_ff);

      mode_after = mode_now || fl_enum;
      s_valid    = req_data.end_of_input || (p_valid && mode_after);

      // After-keyword marks.
      ae_in = ae_ff;
      ac_in = ac_ff;
      if (fl_enum) begin
         ae_in = 1'b1; ac_in = 1'b0;
      end else if (fl_class) begin
         ae_in = 1'b0; ac_in = 1'b1;
      end else if (fl_int || fl_ident) begin
         ae_in = 1'b0; ac_in = 1'b0;
      end
      if (p_valid && mode_after && !req_data.end_of_input) begin
         ae_in = 1'b0; ac_in = 1'b0;
      end

      // Next word state.
      if (start_word || (do_add && !do_flush)) begin
         len_in = a_len; acc_in = a_acc; fdig_in = a_dig; fid_in = a_id;
         fseen_in = a_seen; neg_in = a_neg; km_in = a_km;
      end else if (do_flush || clear_word) begin
         len_in = '0; acc_in = '0; fdig_in = 1'b0; fid_in = 1'b0;
         fseen_in = 1'b0; neg_in = 1'b0; km_in = 2'b00;
      end else begin
         len_in = len_ff; acc_in = acc_ff; fdig_in = fdig_ff; fid_in = fid_ff;
         fseen_in = fseen_ff; neg_in = neg_ff; km_in = km_ff;
      end

      wr_bank  = start_word ? !bank_ff : bank_ff;
      bank_in  = wr_bank;
      mode_in  = mode_after;
   end

   // Result sequencer: first result of an item, identifier replay and the trailing token.
   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      rlen_in  = rlen_ff;
      rbank_in = rbank_ff;
      pend_in  = pend_ff;
      pkind_in = pkind_ff;
      pval_in  = pval_ff;
      load     = 1'b0;
      rsp_in   = rsp_ff;
      ch_last  = (LW'(idx_ff) + LW'(1)) == rlen_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               pend_in  = s_valid;
               pkind_in = s_kind;
               pval_in  = s_value;
               if (fl_ident) begin
                  state_in = ST_RD;
                  idx_in   = '0;
                  rlen_in  = f_len;
                  rbank_in = bank_ff;
               end else if (fl_enum || fl_class || fl_int) begin
                  load = 1'b1;
                  rsp_in = make_rsp(fl_enum ? TK_ENUM : (fl_class ? TK_CLASS : TK_INTEGER),
                                    fl_int ? (f_neg ? (32'd0 - f_acc) : f_acc) : 32'd0,
                                    8'd0, 1'b1, !s_valid, line_in);
                  state_in = s_valid ? ST_PEND : ST_IDLE;
               end else if (s_valid) begin
                  load    = 1'b1;
                  rsp_in  = make_rsp(s_kind, s_value, 8'd0, 1'b1, 1'b1, line_in);
                  pend_in = 1'b0;
               end
            end
         end
         ST_RD: begin
            state_in = ST_CH;
         end
         ST_CH: begin
            if (slot_free) begin
               load   = 1'b1;
               rsp_in = make_rsp(TK_IDENT, 32'd0, rd_data, ch_last,
                                 ch_last && !pend_ff, line_ff);
               idx_in = idx_ff + IW'(1);
               if (ch_last) begin
                  state_in = pend_ff ? ST_PEND : ST_IDLE;
               end else begin
                  state_in = ST_RD;
               end
            end
         end
         default: begin
            if (slot_free) begin
               load     = 1'b1;
               rsp_in   = make_rsp(pkind_ff, pval_ff, 8'd0, 1'b1, 1'b1, line_ff);
               pend_in  = 1'b0;
               state_in = ST_IDLE;
            end
         end
      endcase
   end

   // Character store.
   edt_word_mem #(
      .MAX_LEXEME(MAX_LEXEME)
   ) u_word_mem (
      .clock   (clock),
      .wr_en   (accept && do_add),
      .wr_addr ({wr_bank, a_pos[IW-1:0]}),
      .wr_data (ch),
      .rd_en   (state_ff == ST_RD),
      .rd_addr ({rbank_ff, idx_ff}),
      .rd_data (rd_data)
   );

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         phase_ff <= PH_IDLE;
         saw_ff   <= 1'b0;
         mode_ff  <= 1'b0;
         ae_ff    <= 1'b0;
         ac_ff    <= 1'b0;
         depth_ff <= '0;
         line_ff  <= '0;
         len_ff   <= '0;
         acc_ff   <= '0;
         fdig_ff  <= 1'b0;
         fid_ff   <= 1'b0;
         fseen_ff <= 1'b0;
         neg_ff   <= 1'b0;
         km_ff    <= 2'b00;
         bank_ff  <= 1'b0;
         pend_ff  <= 1'b0;
         rspv_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
         if (accept) begin
            phase_ff <= phase_in;
            saw_ff   <= saw_in;
            mode_ff  <= mode_in;
            ae_ff    <= ae_in;
            ac_ff    <= ac_in;
            depth_ff <= depth_in;
            line_ff  <= line_in;
            len_ff   <= len_in;
            acc_ff   <= acc_in;
            fdig_ff  <= fdig_in;
            fid_ff   <= fid_in;
            fseen_ff <= fseen_in;
            neg_ff   <= neg_in;
            km_ff    <= km_in;
            bank_ff  <= bank_in;
         end
         if (load) begin
            rspv_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rspv_ff <= 1'b0;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      idx_ff   <= idx_in;
      rlen_ff  <= rlen_in;
      rbank_ff <= rbank_in;
      pkind_ff <= pkind_in;
      pval_ff  <= pval_in;
      if (load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rspv_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   // A memory read is always followed by presenting its character.
   a_rd_then_ch: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RD) |=> (state_ff == ST_CH))
      else $error("replay read not followed by character state");

   // The replay index stays inside the stored word.
   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CH) |-> (LW'(idx_ff) < rlen_ff))
      else $error("replay index beyond word length");

   // An end token always closes its item.
   a_end_last: assert property (@(posedge clock) disable iff (reset)
      (rspv_ff && (rsp_ff.token_kind == TK_END)) |-> rsp_ff.item_last)
      else $error("end token without item_last");
`endif

endmodule

// ===== rtl/core/edt_word_mem.sv =====
// Two-bank word character store with a registered read port.
`timescale 1ns / 1ps
module edt_word_mem
   import edt_pkg::*;
#(
   parameter int MAX_LEXEME = MAX_LEXEME_DEFAULT
) (
   input  logic                            clock,
   input  logic                            wr_en,
   input  logic [$clog2(MAX_LEXEME):0]     wr_addr,
   input  logic [7:0]                      wr_data,
   input  logic                            rd_en,
   input  logic [$clog2(MAX_LEXEME):0]     rd_addr,
   output logic [7:0]                      rd_data
);

   // Each bank spans the full index range so the bank bit can lead the address.
   localparam int DEPTH = 2 ** ($clog2(MAX_LEXEME) + 1);

   logic [7:0] mem [DEPTH];
   logic [7:0] rd_data_ff;

   // One bank holds the word being replayed while the other takes a new word.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== test/edt_checker.sv =====
// Checker for the enum declaration tokenizer: predicts tokens and compares results.
`timescale 1ns / 1ps
module edt_checker
   import edt_pkg::*;
#(
   parameter int MAX_LEXEME = MAX_LEXEME_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_stall,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_stall,
   input  rsp_type rsp_data,
   output int      fail_count,
   output int      pending_count
);

   typedef enum logic [2:0] {
      SCAN_IDLE, SCAN_WORD, SCAN_SLASH, SCAN_BLOCK, SCAN_LINE
   } scan_type;

   // Predicted scanner state.
   scan_type    phase;
   logic [7:0]  word_buf [MAX_LEXEME];
   int          word_len;
   logic [31:0] acc;
   logic        w_sign, w_digits, w_ident, w_seen;
   logic        m_enum, m_class;
   logic        saw_star, enum_active, after_enum, after_class;
   logic [15:0] depth, lines;

   rsp_type token_queue [$];
   rsp_type item_tokens [$];

   function automatic logic is_blank(input logic [7:0] c);
      return c == CH_SPACE || c == CH_TAB || c == CH_LF;
   endfunction

   task automatic push_token(input logic [3:0] kind, input logic [31:0] value,
                             input logic [7:0] nch, input logic tlast);
      rsp_type r;
      r.token_kind  = kind;
      r.token_value = value;
      r.name_char   = nch;
      r.token_last  = tlast;
      r.item_last   = 1'b0;
      r.line_count  = lines;
      item_tokens.push_back(r);
   endtask

   task automatic reset_word();
      word_len = 0;
      acc      = '0;
      {w_sign, w_digits, w_ident, w_seen} = '0;
      {m_enum, m_class} = '0;
   endtask

   task automatic append_char(input logic [7:0] c);
      int pos;
      pos = word_len;
      if (pos >= MAX_LEXEME) return;
      word_buf[pos] = c;
      if (pos == 0) begin
         w_digits = 1'b1;
         w_sign   = is_sign(c);
         w_ident  = 1'b0;
         w_seen   = 1'b0;
         if (is_letter(c)) begin
            w_digits = 1'b0;
            w_sign   = 1'b0;
            w_ident  = 1'b1;
         end
         m_enum  = 1'b1;
         m_class = 1'b1;
      end
      if (is_digit(c)) begin
         w_seen = 1'b1;
         acc    = acc * 32'd10 + 32'(c - 8'h30);
      end else if (is_letter(c)) begin
         w_digits = 1'b0;
      end
      if (pos >= 4 || KW_ENUM[pos % 4] != c) m_enum = 1'b0;
      if (pos >= 5 || KW_CLASS[pos % 5] != c) m_class = 1'b0;
      word_len = pos + 1;
   endtask

   // Close the pending word and emit whatever token it forms.
   task automatic close_word();
      if (word_len == 4 && m_enum) begin
         enum_active = 1'b1;
         push_token(TK_ENUM, '0, '0, 1'b1);
         after_enum  = 1'b1;
         after_class = 1'b0;
      end else if (word_len == 5 && m_class) begin
         push_token(TK_CLASS, '0, '0, 1'b1);
         after_enum  = 1'b0;
         after_class = 1'b1;
      end else if (w_digits && w_seen) begin
         if (enum_active) begin
            push_token(TK_INTEGER, (word_buf[0] == CH_MINUS) ? -acc : acc, '0, 1'b1);
            {after_enum, after_class} = '0;
         end
      end else if (w_ident) begin
         if (enum_active || after_enum || after_class) begin
            for (int i = 0; i < word_len; i++)
               push_token(TK_IDENT, '0, word_buf[i], i + 1 == word_len);
            {after_enum, after_class} = '0;
         end
      end
      reset_word();
   endtask

   task automatic punctuation(input logic [3:0] kind, input logic [31:0] value);
      if (enum_active) begin
         push_token(kind, value, '0, 1'b1);
         {after_enum, after_class} = '0;
      end
   endtask

   task automatic start_char(input logic [7:0] c);
      logic [15:0] old;
      phase = SCAN_IDLE;
      if (is_blank(c)) return;
      if (c == CH_LBRACE) begin
         if (depth != 16'hffff) depth++;
         punctuation(TK_LBRACE, 32'(depth));
      end else if (c == CH_RBRACE) begin
         old = depth;
         if (depth != 0) depth--;
         punctuation(TK_RBRACE, 32'(old));
      end else if (c == CH_EQUALS) punctuation(TK_EQUALS, '0);
      else if (c == CH_SEMI) punctuation(TK_SEMI, '0);
      else if (c == CH_COMMA) punctuation(TK_COMMA, '0);
      else if (c == CH_SLASH) phase = SCAN_SLASH;
      else if (is_digit(c) || is_letter(c) || is_sign(c)) begin
         reset_word();
         append_char(c);
         phase = SCAN_WORD;
      end
   endtask

   // Work out every token caused by one accepted request.
   task automatic predict_tokens(input req_type rq);
      logic [7:0] c;
      c = rq.character;
      item_tokens.delete();
      if (rq.leave_enum_mode) enum_active = 1'b0;
      if (rq.end_of_input) begin
         if (phase == SCAN_WORD) close_word();
         push_token(TK_END, '0, '0, 1'b1);
         phase = SCAN_IDLE;
         reset_word();
         saw_star = 1'b0;
      end else begin
         if (c == CH_LF) lines++;
         case (phase)
            SCAN_BLOCK: begin
               if (saw_star && c == CH_SLASH) phase = SCAN_IDLE;
               else saw_star = (c == CH_STAR);
            end
            SCAN_LINE: begin
               if (c == CH_LF) phase = SCAN_IDLE;
            end
            SCAN_SLASH: begin
               if (c == CH_STAR) begin
                  phase    = SCAN_BLOCK;
                  saw_star = 1'b0;
               end else if (c == CH_SLASH) phase = SCAN_LINE;
               else start_char(c);
            end
            SCAN_WORD: begin
               if (is_digit(c) || is_letter(c)) begin
                  append_char(c);
                  if (word_len >= MAX_LEXEME) begin
                     close_word();
                     phase = SCAN_IDLE;
                  end
               end else begin
                  close_word();
                  start_char(c);
               end
            end
            default: start_char(c);
         endcase
      end
      if (item_tokens.size() > 0) item_tokens[$].item_last = 1'b1;
      foreach (item_tokens[i]) token_queue.push_back(item_tokens[i]);
   endtask

   // Watch both channels and compare at each accepted result.
   always @(posedge clock) begin
      rsp_type want;
      int      errs;
      errs = 0;
      if (reset) begin
         phase = SCAN_IDLE;
         reset_word();
         {saw_star, enum_active, after_enum, after_class} = '0;
         depth = '0;
         lines = '0;
         token_queue.delete();
         fail_count    <= 0;
         pending_count <= 0;
      end else begin
         if (req_valid && !req_stall) predict_tokens(req_data);
         if (rsp_valid && !rsp_stall) begin
            if (token_queue.size() == 0) begin
               $error("unexpected result: %p", rsp_data);
               errs++;
            end else begin
               want = token_queue.pop_front();
               if (rsp_data.token_kind !== want.token_kind) begin
                  $error("token_kind expected %0d actual %0d", want.token_kind,
                         rsp_data.token_kind);
                  errs++;
               end
               if (rsp_data.token_value !== want.token_value) begin
                  $error("token_value expected %0d actual %0d", want.token_value,
                         rsp_data.token_value);
                  errs++;
               end
               if (rsp_data.name_char !== want.name_char) begin
                  $error("name_char expected %0h actual %0h", want.name_char,
                         rsp_data.name_char);
                  errs++;
               end
               if (rsp_data.token_last !== want.token_last) begin
                  $error("token_last expected %0b actual %0b", want.token_last,
                         rsp_data.token_last);
                  errs++;
               end
               if (rsp_data.item_last !== want.item_last) begin
                  $error("item_last expected %0b actual %0b", want.item_last,
                         rsp_data.item_last);
                  errs++;
               end
               if (rsp_data.line_count !== want.line_count) begin
                  $error("line_count expected %0d actual %0d", want.line_count,
                         rsp_data.line_count);
                  errs++;
               end
            end
         end
         fail_count    <= fail_count + errs;
         pending_count <= token_queue.size();
      end
   end

endmodule

// ===== test/tb_enum_declaration_tokenizer.sv =====
// Testbench top for the enum declaration tokenizer: stimulus, pacing and verdict.
`timescale 1ns / 1ps
module tb_enum_declaration_tokenizer;
   import edt_pkg::*;

   localparam int CYCLE_LIMIT = 400000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;
   int      fail_count;
   int      pending_count;
   int      cycle_count = 0;
   int      send_idle_pct = 12;
   int      recv_idle_pct = 57;
   int      hold_cycles = 0;
   logic    hold_start = 1'b0;

   enum_declaration_tokenizer u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   edt_checker u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .fail_count(fail_count), .pending_count(pending_count)
   );

   always #5 clock = ~clock;

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Receiver stall, with an optional long hold-off.
   always @(posedge clock) begin
      if (hold_start) begin
         rsp_stall   <= 1'b1;
         hold_cycles <= 300;
      end else if (hold_cycles > 0) begin
         rsp_stall   <= 1'b1;
         hold_cycles <= hold_cycles - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // Offer one request, with random idle cycles before it, and wait for acceptance.
   task automatic send_request(input logic [7:0] c, input logic eoi, input logic leave);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{character: c, end_of_input: eoi, leave_enum_mode: leave};
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_request(s[i], 1'b0, 1'b0);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   // One random request, mostly from well-formed enum text.
   task automatic random_request();
      string pieces [14];
      string s;
      int    k;
      pieces = '{"enum ", "class ", "{", "}", ",", ";", "=", " -", "+", "\n",
                 "/* x*/", "// c\n", "Id_", "42 "};
      k = $urandom_range(99);
      if (k < 3) send_request(8'h00, 1'b1, 1'($urandom_range(1)));
      else if (k < 6) send_request(8'($urandom_range(255)), 1'b0, 1'($urandom_range(1)));
      else if (k < 40) send_request(8'("a" + $urandom_range(25)), 1'b0, 1'b0);
      else if (k < 55) send_request(8'("0" + $urandom_range(9)), 1'b0, 1'b0);
      else begin
         s = pieces[$urandom_range(13)];
         send_text(s);
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: keywords, identifiers, integers, punctuation, comments, limits.
      send_text("enum E{A=-7,");
      send_text("b=+12;}");
      send_text("class K /x");
      send_request(8'hff, 1'b0, 1'b0);
      send_request(8'h00, 1'b1, 1'b0);
      wait_drained();
      send_text("enum 4294967296");
      send_request(8'h00, 1'b1, 1'b1);
      send_text("/*\n*/");
      wait_drained();
      send_text("enum _abcdefghijklmnopqrstuvwxyz01234x ");
      send_text("5a +b - }}}");
      send_request(8'h00, 1'b1, 1'b0);
      wait_drained();

      // Random phases with different idling, then a long receiver hold-off.
      for (int i = 0; i < 24; i++) random_request();
      wait_drained();
      send_idle_pct = 57;
      recv_idle_pct = 12;
      for (int i = 0; i < 20; i++) random_request();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_start <= 1'b1;
      @(posedge clock);
      hold_start <= 1'b0;
      send_text("enum Q{alpha,beta_long_name,gamma=99,delta};");
      for (int i = 0; i < 10; i++) random_request();
      send_request(8'h00, 1'b1, 1'b0);
      wait_drained();

      repeat (100) @(posedge clock);
      if (fail_count == 0) $display("Simulation PASSED");
      else $display("Simulation FAILED");
      $finish;
   end

endmodule
